// File: hdl/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Needs no other file; include it inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// Package for the sorted priority queue: sizes, status codes and cell link types.
// Depends on nothing; every queue module imports it.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         count_type;

   // Broadcast to every cell in the cycle a beat is taken.
   typedef struct packed {
      logic      push;
      logic      pop;
      data_type  value;
      count_type count;
   } cmd_type;

   // What one cell hands to its neighbors.
   typedef struct packed {
      data_type entry;
      logic     gt;
   } link_type;

endpackage

`default_nettype wire

// File: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: control, count and a row of cells.
// Depends on spq_pkg, spq_cell and assert_macros.svh.
//
//   channel | direction | tdata (low bit up)             | tuser
//   req     | in        | value[31:0]                    | action
//   rsp     | out       | popped[31:0], occupancy[36:32] | status[1:0]
//
// Every cell compares its entry with the pushed value and shifts in the same
// clock, so one beat a cycle is sustained while the result side keeps up.
// The result is held in an output register from the cycle after the request beat.
// A request is taken while that register is empty or being drained.
// Reset clears the count and the output valid; entries are never cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic [0:0]  req_tuser,   // action[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // popped[31:0], occupancy[36:32], zero pad
   output logic [1:0]       rsp_tuser    // status[1:0]
);
   import spq_pkg::*;
   `include "assert_macros.svh"

   count_type          count_ff;
   count_type          count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   data_type           popped_ff;
   data_type           popped_in;
   logic [STAT_W-1:0]  status_ff;
   logic [STAT_W-1:0]  status_in;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;
   logic               req_fire;
   logic               is_full;
   logic               is_empty;
   cmd_type            cmd;
   link_type           link_w [DEPTH];

   // The output register parts the two sides: a new beat may enter in the
   // same cycle that the waiting result is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);

   always_comb begin
      cmd.push  = req_fire && (req_tuser[0] == ACT_PUSH) && !is_full;
      cmd.pop   = req_fire && (req_tuser[0] == ACT_POP) && !is_empty;
      cmd.value = data_type'(req_tdata);
      cmd.count = count_ff;
   end

   // Count, status and the popped value for the result beat.
   always_comb begin
      count_in  = count_ff;
      popped_in = '0;
      status_in = ST_OK;
      if (req_tuser[0] == ACT_PUSH) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            popped_in = link_w[0].entry;
            count_in  = count_ff - 1'b1;
         end
      end
      occ_in       = OCC_W'(count_in);
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
         end
      end
      if (req_fire) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(40 - DATA_W - OCC_W){1'b0}}, occ_ff, popped_ff};
   assign rsp_tuser  = status_ff;

   // The row of cells; slot 0 holds the smallest entry. Cell 0 sees no left
   // neighbor and the last cell takes nothing from the right on a pop.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type left_w;
      link_type right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_left
         assign left_w = link_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_right
         assign right_w = link_w[i+1];
      end
      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (CNT_W'(i)),
         .left_link  (left_w),
         .right_link (right_w),
         .link_out   (link_w[i])
      );
   end

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH), "count above depth")
   `ASSERT_ALWAYS(a_full_occ, clock, reset, (rsp_valid_ff && status_ff == ST_FULL) |-> (occ_ff == OCC_W'(DEPTH)), "full status with wrong occupancy")
   `ASSERT_ALWAYS(a_empty_occ, clock, reset, (rsp_valid_ff && status_ff == ST_EMPTY) |-> (occ_ff == '0), "empty status with nonzero occupancy")
   `ASSERT_ALWAYS(a_sorted_head, clock, reset, (count_ff >= CNT_W'(2)) |-> (link_w[0].entry <= link_w[1].entry), "head entries out of order")
   `ASSERT_ALWAYS(a_count_step, clock, reset, !$past(req_fire) |-> $stable(count_ff), "count moved without a request beat")

endmodule

`default_nettype wire

// File: hdl/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
   input  wire logic              clock,
   input  wire spq_pkg::cmd_type   cmd,
   input  wire spq_pkg::count_type cell_index,
   input  wire spq_pkg::link_type  left_link,
   input  wire spq_pkg::link_type  right_link,
   output spq_pkg::link_type       link_out
);
   import spq_pkg::*;

   data_type entry_ff;
   data_type entry_in;
   logic     occupied;
   logic     gt;

   always_comb begin
      occupied = (cell_index < cmd.count);
      gt       = occupied && (entry_ff > cmd.value);
      link_out = '{entry: entry_ff, gt: gt};
   end

   // On a push the greater entries move up one slot and the new value lands
   // in the first slot that is free or holds a greater entry.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         if (left_link.gt) begin
            entry_in = left_link.entry;
         end else if (gt || (cell_index == cmd.count)) begin
            entry_in = cmd.value;
         end
      end else if (cmd.pop) begin
         entry_in = right_link.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// File: test/tb_sorted_priority_queue.sv
// Self-checking testbench for sorted_priority_queue: drives push and pop beats,
// predicts every result with its own sorted store, and checks each response beat.
// Depends on spq_pkg and the sorted_priority_queue RTL only.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
   import spq_pkg::*;

   // Cycle budget. The slowest correct run has about 1325 beats, each held up at most
   // by one sender gap and one receiver stall, so this limit leaves a wide margin.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 1300;
   // The last beats of the random part run with both sides always ready.
   localparam int QUIET_FROM   = 1100;

   // One result as the block reports it.
   typedef struct {
      data_type         popped;
      logic [STAT_W-1:0] status;
      logic [OCC_W-1:0]  occupancy;
   } queue_result_type;

   // One row of the directed table. Rows with known_result set carry their
   // expected result. All other rows are checked against the predictor.
   typedef struct {
      logic             action;
      data_type         value;
      bit               known_result;
      queue_result_type result;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;
   logic [0:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [39:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;

   // Predictor state. It holds its own sorted copy of the store and the count.
   data_type          shadow_store [DEPTH];
   int                shadow_count;

   queue_result_type  pending_results [$];
   stim_row_type      directed_rows [$];

   int                error_count;
   int                cycle_count;
   int                beats_sent;
   int                results_seen;
   int                push_count;
   int                pop_count;
   int                full_hits;
   int                empty_hits;
   bit                quiet_tail;

   sorted_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value[31:0]
      .req_tuser  (req_tuser),   // action[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // popped[31:0], occupancy[36:32], zero pad
      .rsp_tuser  (rsp_tuser)    // status[1:0]
   );

   // Every input has a known value from time zero.
   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
   end

   always #10 clock = ~clock;

   // The watchdog ends the run if the handshakes stop making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Predict the result of one beat and update the shadow store. A push moves
   // every held value that is strictly greater up one slot. Equal values stay
   // in front, so equal values leave in arrival order. A push to a full queue
   // or a pop from an empty one leaves the store alone and sets a status.
   function automatic queue_result_type predict_queue_step(input logic action,
                                                           input data_type value);
      queue_result_type res;
      int               slot;
      res.popped = '0;
      res.status = ST_OK;
      if (action == ACT_PUSH) begin
         if (shadow_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            slot = shadow_count;
            while (slot > 0 && shadow_store[slot-1] > value) begin
               shadow_store[slot] = shadow_store[slot-1];
               slot--;
            end
            shadow_store[slot] = value;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.popped = shadow_store[0];
            for (slot = 1; slot < shadow_count; slot++)
               shadow_store[slot-1] = shadow_store[slot];
            shadow_count--;
         end
      end
      res.occupancy = shadow_count[OCC_W-1:0];
      return res;
   endfunction

   task automatic add_row(input logic action, input data_type value, input bit known,
                          input data_type popped, input logic [STAT_W-1:0] status,
                          input int occupancy);
      stim_row_type row;
      row.action           = action;
      row.value            = value;
      row.known_result     = known;
      row.result.popped    = popped;
      row.result.status    = status;
      row.result.occupancy = occupancy[OCC_W-1:0];
      directed_rows.push_back(row);
   endtask

   // Present one request beat from a falling edge, wait for its acceptance
   // at a rising edge, then queue its expected result. The sender may first
   // hold off for a burst of idle cycles. The valid signal is written once
   // per falling edge, so it never drops and rises within one time step.
   task automatic send_beat(input logic action, input data_type value,
                            input bit known, input queue_result_type known_res);
      queue_result_type predicted;
      int               gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_queue_step(action, value);
      pending_results.push_back(known ? known_res : predicted);
      beats_sent++;
      if (action == ACT_PUSH) push_count++;
      else pop_count++;
      if (predicted.status == ST_FULL) full_hits++;
      if (predicted.status == ST_EMPTY) empty_hits++;
      @(negedge clock);
   endtask

   // The receiver stalls in random bursts and is always ready in the quiet tail.
   // A new burst only starts after a ready cycle, so bursts never run together.
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && rsp_tready && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check each accepted response beat against the oldest expectation.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat tdata=%h tuser=%h",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.popped)
               report_mismatch($sformatf("result %0d popped %0d, expected %0d",
                  results_seen, $signed(rsp_tdata[31:0]), want.popped));
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("result %0d status %0d, expected %0d",
                  results_seen, rsp_tuser, want.status));
            if (rsp_tdata[36:32] !== want.occupancy)
               report_mismatch($sformatf("result %0d occupancy %0d, expected %0d",
                  results_seen, rsp_tdata[36:32], want.occupancy));
         end
      end
   end

   initial begin
      queue_result_type none;
      stim_row_type     row;
      logic             action;
      data_type         value;
      int               seg_len;
      int               push_pct;
      int               pick;
      int               rnd_sent;

      none.popped    = '0;
      none.status    = ST_OK;
      none.occupancy = '0;
      error_count    = 0;
      cycle_count    = 0;
      beats_sent     = 0;
      results_seen   = 0;
      push_count     = 0;
      pop_count      = 0;
      full_hits      = 0;
      empty_hits     = 0;
      quiet_tail     = 1'b0;
      shadow_count   = 0;

      // The directed table. The first rows exercise the empty queue and the
      // two signed extremes, where the results are plain. A pop from empty
      // carries a busy value that the block must ignore.
      add_row(ACT_POP,  32'shFFFFFFFF, 1, 32'sh0,        ST_EMPTY, 0);
      add_row(ACT_PUSH, 32'sh7FFFFFFF, 1, 32'sh0,        ST_OK,    1);
      add_row(ACT_PUSH, 32'sh80000000, 1, 32'sh0,        ST_OK,    2);
      add_row(ACT_POP,  32'sh0,        1, 32'sh80000000, ST_OK,    1);
      add_row(ACT_POP,  32'sh5A5A5A5A, 1, 32'sh7FFFFFFF, ST_OK,    0);
      add_row(ACT_POP,  32'sh0,        1, 32'sh0,        ST_EMPTY, 0);
      // Fill the queue with a mix of signs, repeated values and both extremes
      // twice. The repeats push values equal to ones already held.
      add_row(ACT_PUSH, 32'sd0,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, -32'sd1,       0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd1,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd5,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd5,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sh7FFFFFFF, 0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sh80000000, 0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sh7FFFFFFF, 0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sh80000000, 0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd100,      0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, -32'sd100,     0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd7,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd3,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd2,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sd5,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_PUSH, 32'sh40000000, 0, 32'sh0, ST_OK, 0);
      // The queue is now full, so this push must be refused.
      add_row(ACT_PUSH, 32'sd9,        1, 32'sh0, ST_FULL, DEPTH);
      add_row(ACT_POP,  32'sh0,        0, 32'sh0, ST_OK, 0);
      add_row(ACT_POP,  32'sh0,        0, 32'sh0, ST_OK, 0);

      // Reset is held from time zero and released at a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.action, row.value, row.known_result, row.result);
      end

      // The random part runs in segments. Each segment favors pushes, favors
      // pops or mixes them evenly, so the queue swings between full and empty
      // many times and both refusals come up often. Values mix the extremes,
      // a narrow band that makes many ties, and full 32-bit random words.
      rnd_sent = 0;
      while (rnd_sent < RANDOM_BEATS) begin
         seg_len = $urandom_range(10, 80);
         case ($urandom_range(0, 2))
            0: begin
               push_pct = 85;
            end
            1: begin
               push_pct = 50;
            end
            default: begin
               push_pct = 15;
            end
         endcase
         repeat (seg_len) begin
            if (rnd_sent >= QUIET_FROM) quiet_tail = 1'b1;
            action = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
            pick = $urandom_range(0, 9);
            if (pick == 0)
               value = 32'sh7FFFFFFF;
            else if (pick == 1)
               value = 32'sh80000000;
            else if (pick <= 4)
               value = $signed($urandom_range(0, 8)) - 32'sd4;
            else
               value = $urandom;
            send_beat(action, value, 0, none);
            rnd_sent++;
         end
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding results, then keep clocking so that any stray beat
      // from the output register would be caught.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d beats: %0d pushes, %0d pops, %0d full refusals, %0d empty refusals",
               beats_sent, push_count, pop_count, full_hits, empty_hits);
      $display("checked %0d result beats in %0d cycles, %0d mismatches",
               results_seen, cycle_count, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/tb_sorted_priority_queue.sv
